[design/pfa_pkg.sv]
// shared types and constants of the page frame allocator
`default_nettype none

package pfa_pkg;

    // default number of pages held in the bitmap
    localparam int unsigned PAGES_DEF = 4096;

    // field widths
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned PG_W    = 12;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned STAT_W  = 2;

    // largest page count the count register can express
    localparam int unsigned CNT_MAX = 8191;

    // bitmap word: 64 page flags per memory row
    localparam int unsigned WORD_W  = 64;
    localparam int unsigned BIT_W   = 6;

    // remainder unit: one quotient bit per step over the count width
    localparam int unsigned MSTEP_W = 4;

    // register port
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_PAGE_COUNT = 1'b0;

    // stream payload widths
    localparam int unsigned S_TDATA_W = 24;
    localparam int unsigned M_TDATA_W = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_CURSOR  = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_FREE  = 2'd1,
        ST_RANGE    = 2'd2,
        ST_NOT_USED = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic mod_step;
        logic prep;
        logic run;
    } t_dp_ctl;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic mod_done;
        logic quick;
        logic sweep_done;
    } t_dp_sts;

endpackage

`default_nettype wire

[design/pfa_datapath.sv]
// bitmap memory, search cursor, remainder unit and word scan of the allocator
`default_nettype none

module pfa_datapath #(
    parameter int unsigned PAGES = pfa_pkg::PAGES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pfa_pkg::t_dp_ctl              i_ctl,
    output pfa_pkg::t_dp_sts                   o_sts,
    input  wire logic [pfa_pkg::CNT_W-1:0]     i_cfg_count,
    input  wire logic [pfa_pkg::CMD_W-1:0]     i_item_cmd,
    input  wire logic [pfa_pkg::PG_W-1:0]      i_item_page,
    input  wire logic [pfa_pkg::PG_W-1:0]      i_item_last,
    output logic [pfa_pkg::PG_W-1:0]           o_res_page,
    output logic [pfa_pkg::STAT_W-1:0]         o_res_status
);

    localparam int unsigned CAP   = (PAGES > pfa_pkg::CNT_MAX) ? pfa_pkg::CNT_MAX : PAGES;
    localparam int unsigned WORDS = (CAP + pfa_pkg::WORD_W - 1) / pfa_pkg::WORD_W;
    localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned KW    = WAW + 1;
    localparam int unsigned HPW   = WAW + pfa_pkg::BIT_W;
    localparam int unsigned CW    = pfa_pkg::CNT_W;
    localparam int unsigned BW    = pfa_pkg::BIT_W;
    localparam int unsigned WW    = pfa_pkg::WORD_W;

    localparam logic [CW-1:0]                 CAP_C      = CW'(CAP);
    localparam logic [pfa_pkg::MSTEP_W-1:0]   MSTEP_DONE = pfa_pkg::MSTEP_W'(CW);
    localparam logic [WAW-1:0]                LAST_WORD  = WAW'(WORDS - 1);

    function automatic logic [BW-1:0] first_set(input logic [WW-1:0] v);
        logic [BW-1:0] p;
        p = '0;
        for (int i = WW - 1; i >= 0; i--) begin
            if (v[i]) begin
                p = BW'(i);
            end
        end
        return p;
    endfunction

    // bitmap store, one flag per page
    logic [WW-1:0] r_mem [WORDS];

    // captured item
    pfa_pkg::t_cmd          r_cmd;
    logic [pfa_pkg::PG_W-1:0] r_page;
    logic [pfa_pkg::PG_W-1:0] r_last;
    logic [CW-1:0]          r_cnt;
    logic [pfa_pkg::PG_W-1:0] r_cursor;

    // remainder unit
    logic [CW-1:0]                 r_rem;
    logic [CW-1:0]                 r_num;
    logic [pfa_pkg::MSTEP_W-1:0]   r_mstep;

    // scan setup and pointers
    logic [WAW-1:0] r_sw;
    logic [WAW-1:0] r_lw;
    logic [WAW-1:0] r_wptr;
    logic [KW-1:0]  r_k;
    logic [KW-1:0]  r_nsteps;
    logic [BW-1:0]  r_bit_a;
    logic [BW-1:0]  r_bit_b;

    // read stage
    logic           r_v1;
    logic [WAW-1:0] r_w1;
    logic           r_first1;
    logic           r_last1;
    logic [WW-1:0]  r_rdata;

    // result
    logic [pfa_pkg::PG_W-1:0] r_res_page;
    pfa_pkg::t_status         r_res_status;

    // live page count
    logic [CW-1:0] cnt_live;
    logic [CW-1:0] cur_inc;
    logic          load_alloc;

    assign cnt_live = (i_cfg_count == '0) ? CW'(1) :
                      ((i_cfg_count > CAP_C) ? CAP_C : i_cfg_count);
    assign cur_inc    = {1'b0, r_cursor} + CW'(1);
    assign load_alloc = (pfa_pkg::t_cmd'(i_item_cmd) == pfa_pkg::CMD_ALLOC);

    // restoring remainder step
    logic [CW:0]   trial;
    logic          trial_ge;
    logic [CW-1:0] rem_nx;
    logic          mod_done;

    assign trial    = {r_rem, r_num[CW-1]};
    assign trial_ge = (trial >= {1'b0, r_cnt});
    assign rem_nx   = trial_ge ? CW'(trial - {1'b0, r_cnt}) : CW'(trial);
    assign mod_done = (r_mstep == MSTEP_DONE);

    // scan setup
    logic [CW-1:0]       cnt_m1;
    logic [CW-1:0]       page_x;
    logic [CW-1:0]       last_x;
    logic [CW-1:0]       hi;
    logic [WAW-1:0]      p_sw;
    logic [WAW-1:0]      p_lw;
    logic [KW-1:0]       p_n;
    logic [BW-1:0]       p_bit_a;
    logic [BW-1:0]       p_bit_b;
    logic                p_quick;
    pfa_pkg::t_status    p_status;

    always_comb begin
        cnt_m1   = r_cnt - CW'(1);
        page_x   = {1'b0, r_page};
        last_x   = {1'b0, r_last};
        hi       = (last_x < cnt_m1) ? last_x : cnt_m1;
        p_sw     = '0;
        p_lw     = '0;
        p_n      = '0;
        p_bit_a  = '0;
        p_bit_b  = '0;
        p_quick  = 1'b0;
        p_status = pfa_pkg::ST_OK;
        unique case (r_cmd)
            pfa_pkg::CMD_ALLOC: begin
                p_sw    = WAW'(r_rem >> BW);
                p_lw    = WAW'(cnt_m1 >> BW);
                p_n     = KW'(p_lw) + KW'(2);
                p_bit_a = r_rem[BW-1:0];
                p_bit_b = cnt_m1[BW-1:0];
            end
            pfa_pkg::CMD_RESERVE: begin
                p_sw    = WAW'(page_x >> BW);
                p_lw    = WAW'(hi >> BW);
                p_n     = KW'(p_lw) - KW'(p_sw) + KW'(1);
                p_bit_a = r_page[BW-1:0];
                p_bit_b = hi[BW-1:0];
                p_quick = (page_x > hi);
            end
            pfa_pkg::CMD_FREE: begin
                p_sw    = WAW'(page_x >> BW);
                p_lw    = WAW'(page_x >> BW);
                p_n     = KW'(1);
                p_bit_a = r_page[BW-1:0];
                p_bit_b = r_page[BW-1:0];
                p_quick = (page_x >= r_cnt);
                if (p_quick) begin
                    p_status = pfa_pkg::ST_RANGE;
                end
            end
            pfa_pkg::CMD_CURSOR: begin
                p_quick = 1'b1;
            end
            default: begin
                p_quick = 1'b1;
            end
        endcase
    end

    // read stage: mask of the pages that count in this word
    logic [WW-1:0]  ones;
    logic [WW-1:0]  mask;
    logic [WW-1:0]  free_bits;
    logic           hit;
    logic           used;
    logic [BW-1:0]  pos;
    logic [HPW-1:0] hit_page;
    logic           sweep_done;
    logic           issue;

    always_comb begin
        ones = '1;
        mask = ones;
        unique case (r_cmd)
            pfa_pkg::CMD_ALLOC: begin
                if (r_w1 == r_lw) begin
                    mask = mask & (ones >> (BW'(WW - 1) - r_bit_b));
                end
                // first visit of the start word: pages from the start on
                if (r_first1) begin
                    mask = mask & (ones << r_bit_a);
                end
                // wrapped visit of the start word: pages below the start
                if (r_last1) begin
                    mask = mask & ~(ones << r_bit_a);
                end
            end
            pfa_pkg::CMD_RESERVE: begin
                if (r_w1 == r_sw) begin
                    mask = mask & (ones << r_bit_a);
                end
                if (r_w1 == r_lw) begin
                    mask = mask & (ones >> (BW'(WW - 1) - r_bit_b));
                end
            end
            pfa_pkg::CMD_FREE: begin
                mask = WW'(1) << r_bit_a;
            end
            default: begin
                mask = '0;
            end
        endcase
    end

    assign free_bits = ~r_rdata & mask;
    assign hit       = |free_bits;
    assign used      = |(r_rdata & mask);
    assign pos       = first_set(free_bits);
    assign hit_page  = {r_w1, pos};

    always_comb begin
        unique case (r_cmd)
            pfa_pkg::CMD_ALLOC:   sweep_done = r_v1 & (hit | r_last1);
            pfa_pkg::CMD_RESERVE: sweep_done = r_v1 & r_last1;
            pfa_pkg::CMD_FREE:    sweep_done = r_v1;
            default:              sweep_done = r_v1;
        endcase
    end

    assign issue = i_ctl.run & ~sweep_done & (r_k != r_nsteps);

    // memory write port
    logic           mem_we;
    logic [WAW-1:0] mem_waddr;
    logic [WW-1:0]  mem_wdata;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_w1;
        mem_wdata = r_rdata;
        if (i_ctl.clr) begin
            mem_we    = 1'b1;
            mem_waddr = r_wptr;
            mem_wdata = '0;
        end else if (r_v1) begin
            unique case (r_cmd)
                pfa_pkg::CMD_ALLOC: begin
                    mem_we    = hit;
                    mem_wdata = r_rdata | (WW'(1) << pos);
                end
                pfa_pkg::CMD_RESERVE: begin
                    mem_we    = 1'b1;
                    mem_wdata = r_rdata | mask;
                end
                pfa_pkg::CMD_FREE: begin
                    mem_we    = used;
                    mem_wdata = r_rdata & ~mask;
                end
                default: begin
                    mem_we    = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (issue) begin
            r_rdata <= r_mem[r_wptr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor <= '0;
            r_mstep  <= '0;
            r_wptr   <= '0;
            r_k      <= '0;
            r_nsteps <= '0;
            r_v1     <= 1'b0;
        end else begin
            r_v1 <= issue;
            if (i_ctl.load) begin
                r_mstep <= (load_alloc && (cur_inc >= cnt_live)) ? '0 : MSTEP_DONE;
            end else if (i_ctl.mod_step && !mod_done) begin
                r_mstep <= r_mstep + pfa_pkg::MSTEP_W'(1);
            end
            if (i_ctl.clr) begin
                r_wptr <= r_wptr + WAW'(1);
            end else if (i_ctl.prep) begin
                r_wptr   <= p_sw;
                r_k      <= '0;
                r_nsteps <= p_n;
            end else if (issue) begin
                r_wptr <= (r_wptr == r_lw) ? '0 : r_wptr + WAW'(1);
                r_k    <= r_k + KW'(1);
            end
            if (i_ctl.prep && (r_cmd == pfa_pkg::CMD_CURSOR)) begin
                r_cursor <= r_page;
            end else if (sweep_done && (r_cmd == pfa_pkg::CMD_ALLOC) && hit) begin
                r_cursor <= pfa_pkg::PG_W'(hit_page);
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= pfa_pkg::t_cmd'(i_item_cmd);
            r_page <= i_item_page;
            r_last <= i_item_last;
            r_cnt  <= cnt_live;
            r_num  <= cur_inc;
            r_rem  <= (load_alloc && (cur_inc >= cnt_live)) ? '0 : cur_inc;
        end else if (i_ctl.mod_step && !mod_done) begin
            r_rem <= rem_nx;
            r_num <= r_num << 1;
        end
        if (i_ctl.prep) begin
            r_sw    <= p_sw;
            r_lw    <= p_lw;
            r_bit_a <= p_bit_a;
            r_bit_b <= p_bit_b;
            if (p_quick) begin
                r_res_page   <= '0;
                r_res_status <= p_status;
            end
        end
        if (issue) begin
            r_w1     <= r_wptr;
            r_first1 <= (r_k == '0);
            r_last1  <= (r_k == (r_nsteps - KW'(1)));
        end
        if (sweep_done) begin
            unique case (r_cmd)
                pfa_pkg::CMD_ALLOC: begin
                    r_res_page   <= hit ? pfa_pkg::PG_W'(hit_page) : '0;
                    r_res_status <= hit ? pfa_pkg::ST_OK : pfa_pkg::ST_NO_FREE;
                end
                pfa_pkg::CMD_FREE: begin
                    r_res_page   <= '0;
                    r_res_status <= used ? pfa_pkg::ST_OK : pfa_pkg::ST_NOT_USED;
                end
                default: begin
                    r_res_page   <= '0;
                    r_res_status <= pfa_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_sts.clr_last   = (r_wptr == LAST_WORD);
    assign o_sts.mod_done   = mod_done;
    assign o_sts.quick      = p_quick;
    assign o_sts.sweep_done = sweep_done;

    assign o_res_page   = r_res_page;
    assign o_res_status = r_res_status;

endmodule

`default_nettype wire

[design/pfa_ctrl.sv]
// sequencing state machine of the allocator
`default_nettype none

module pfa_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic              i_out_free,
    output logic                   o_out_load,
    output pfa_pkg::t_dp_ctl       o_ctl,
    input  wire pfa_pkg::t_dp_sts  i_sts
);

    typedef enum logic [5:0] {
        S_CLEAR  = 6'b000001,
        S_IDLE   = 6'b000010,
        S_MOD    = 6'b000100,
        S_PREP   = 6'b001000,
        S_SWEEP  = 6'b010000,
        S_RESULT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        o_out_load = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_ctl.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_MOD;
                end
            end
            S_MOD: begin
                o_ctl.mod_step = 1'b1;
                if (i_sts.mod_done) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_ctl.prep = 1'b1;
                n_state    = i_sts.quick ? S_RESULT : S_SWEEP;
            end
            S_SWEEP: begin
                o_ctl.run = 1'b1;
                if (i_sts.sweep_done) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_out_free) begin
                    o_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

[design/page_frame_allocator_core.sv]
// top level of the next-fit bitmap page frame allocator
//
// channel   dir  handshake             payload
// s stream  in   i_s_tvalid/o_s_tready i_s_tuser command, i_s_tdata page and end page
// m stream  out  o_m_tvalid/i_m_tready o_m_tdata result page and status
// apb       in   psel/penable/pwrite   page_count_in_use at byte address 0
//
// one command at a time; its result waits in the core until the output register is free,
//   so one unread result leaves the input open and a second one stalls it
// an allocate scans words, after a bit-serial remainder over the count width when
//   cursor + 1 is not below the page count; the sweep reads one 64-page word per cycle,
//   at most (count - 1)/64 + 2 words (65); free reads one word, reserve the words in range,
//   set-cursor, out-of-range free and empty reserve read none; reset clears every word
`default_nettype none

module page_frame_allocator_core #(
    parameter int unsigned PAGES = pfa_pkg::PAGES_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // input stream
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [pfa_pkg::S_TDATA_W-1:0]   i_s_tdata,  // [11:0] page_number, [23:12] end_page
    input  wire logic [pfa_pkg::CMD_W-1:0]       i_s_tuser,  // [1:0] command
    // result stream
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [pfa_pkg::M_TDATA_W-1:0]        o_m_tdata,  // [11:0] result_page, [13:12] status
    // register port
    input  wire logic                            i_psel,
    input  wire logic                            i_penable,
    input  wire logic                            i_pwrite,
    input  wire logic [pfa_pkg::PADDR_W-1:0]     i_paddr,
    input  wire logic [pfa_pkg::PDATA_W-1:0]     i_pwdata,
    output logic [pfa_pkg::PDATA_W-1:0]          o_prdata,
    output logic                                 o_pready
);

    // reset value of the page count: the whole store, capped at what 13 bits hold
    localparam int unsigned CNT_RST = (PAGES > pfa_pkg::CNT_MAX) ? pfa_pkg::CNT_MAX : PAGES;

    localparam int unsigned PG_W = pfa_pkg::PG_W;

    // page count register
    logic [pfa_pkg::CNT_W-1:0] r_page_count;
    logic                      reg_sel;
    logic                      reg_wr;

    // register index is the word address; the low byte-offset bits are ignored
    assign reg_sel  = (i_paddr[2] == pfa_pkg::REG_PAGE_COUNT);
    assign o_pready = 1'b1;
    assign reg_wr   = i_psel & i_penable & i_pwrite & o_pready & reg_sel;
    assign o_prdata = reg_sel ? pfa_pkg::PDATA_W'(r_page_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_count <= pfa_pkg::CNT_W'(CNT_RST);
        end else if (reg_wr) begin
            r_page_count <= i_pwdata[pfa_pkg::CNT_W-1:0];
        end
    end

    // controller and datapath
    pfa_pkg::t_dp_ctl ctl;
    pfa_pkg::t_dp_sts sts;
    logic             in_ready;
    logic             out_load;
    logic             out_free;
    logic [PG_W-1:0]  res_page;
    logic [pfa_pkg::STAT_W-1:0] res_status;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (in_ready),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .o_ctl      (ctl),
        .i_sts      (sts)
    );

    pfa_datapath #(
        .PAGES (PAGES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .o_sts        (sts),
        .i_cfg_count  (r_page_count),
        .i_item_cmd   (i_s_tuser),
        .i_item_page  (i_s_tdata[PG_W-1:0]),
        .i_item_last  (i_s_tdata[2*PG_W-1:PG_W]),
        .o_res_page   (res_page),
        .o_res_status (res_status)
    );

    assign o_s_tready = in_ready;

    // output register: holds one result until its transfer completes
    logic                        r_m_tvalid;
    logic [PG_W-1:0]             r_m_page;
    logic [pfa_pkg::STAT_W-1:0]  r_m_status;

    assign out_free = ~r_m_tvalid | i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_m_page   <= res_page;
            r_m_status <= res_status;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = pfa_pkg::M_TDATA_W'({r_m_status, r_m_page});

endmodule

`default_nettype wire

[test/tb_page_frame_allocator_core.sv]
// self-checking stream testbench for the next-fit bitmap page frame allocator
module tb_page_frame_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    // widths taken from the shared package
    localparam int unsigned PG_W      = pfa_pkg::PG_W;
    localparam int unsigned CNT_W     = pfa_pkg::CNT_W;
    localparam int unsigned CMD_W     = pfa_pkg::CMD_W;
    localparam int unsigned STAT_W    = pfa_pkg::STAT_W;
    localparam int unsigned PADDR_W   = pfa_pkg::PADDR_W;
    localparam int unsigned PDATA_W   = pfa_pkg::PDATA_W;
    localparam int unsigned S_TDATA_W = pfa_pkg::S_TDATA_W;
    localparam int unsigned M_TDATA_W = pfa_pkg::M_TDATA_W;
    localparam int unsigned PAGES_DEF = pfa_pkg::PAGES_DEF;

    // run limits
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;
    localparam int unsigned PHASE_ITEMS  = 40;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam logic [PADDR_W-1:0] PAGE_COUNT_ADDR = PADDR_W'(4 * pfa_pkg::REG_PAGE_COUNT);

    // one command as it travels on the input stream
    typedef struct packed {
        pfa_pkg::t_cmd    op;
        logic [PG_W-1:0]  page;
        logic [PG_W-1:0]  last;
    } t_command;

    // one result as it comes back on the output stream
    typedef struct packed {
        logic [PG_W-1:0]  page;
        pfa_pkg::t_status status;
    } t_outcome;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    always #4 i_clk = ~i_clk;

    // stream and register port signals; those the bench drives are known from time zero
    logic                  s_valid = 1'b0;
    logic [S_TDATA_W-1:0]  s_data  = '0;
    logic [CMD_W-1:0]      s_user  = '0;
    logic                  m_ready = 1'b0;
    logic                  o_s_tready;
    logic                  o_m_tvalid;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [PADDR_W-1:0]    paddr   = '0;
    logic [PDATA_W-1:0]    pwdata  = '0;
    logic [PDATA_W-1:0]    o_prdata;
    logic                  o_pready;

    page_frame_allocator_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_data),     // [11:0] page_number, [23:12] end_page
        .i_s_tuser  (s_user),     // [1:0] command
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_ready),
        .o_m_tdata  (o_m_tdata),  // [11:0] result_page, [13:12] status
        .i_psel     (psel),
        .i_penable  (penable),
        .i_pwrite   (pwrite),
        .i_paddr    (paddr),
        .i_pwdata   (pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    // shadow of the allocator: used flags, search cursor and page count register
    bit              page_taken [PAGES_DEF];
    logic [PG_W-1:0] shadow_cursor = '0;
    logic [CNT_W-1:0] shadow_count = CNT_W'(PAGES_DEF);

    // commands waiting to be sent and results waiting to arrive
    t_command queued_commands [$];
    t_outcome awaited_results [$];

    int unsigned queued_total   = 0;
    int unsigned accepted_total = 0;
    int unsigned results_seen   = 0;
    int unsigned error_count    = 0;
    int unsigned cycle_count    = 0;
    int unsigned phase_count    = 0;
    int unsigned alloc_hits     = 0;
    int unsigned alloc_misses   = 0;

    // idling control
    bit          steady     = 1'b0;   // phase with no idling on either side
    bit          s_fire     = 1'b0;   // input transfer at the last rising edge
    int unsigned gap_left   = 0;
    int unsigned stall_left = 0;
    int unsigned hold_left  = 0;
    bit          hold_done  = 1'b0;
    t_command    outgoing;

    // page count as the allocator applies it: zero acts as one, saturated at the bitmap size
    function automatic int unsigned live_span();
        int unsigned span;
        span = shadow_count;
        if (span == 0)
            span = 1;
        if (span > PAGES_DEF)
            span = PAGES_DEF;
        return span;
    endfunction

    // next-fit allocator behaviour for one command; updates the shadow state
    function automatic t_outcome allocator_step(t_command c);
        t_outcome    o;
        int unsigned span;
        int unsigned probe;
        int unsigned n;
        int unsigned i;
        bit          found;
        span     = live_span();
        o.page   = '0;
        o.status = pfa_pkg::ST_OK;
        found    = 1'b0;
        case (c.op)
            pfa_pkg::CMD_ALLOC: begin
                // first probe is the page after the cursor, wrapping at the count
                probe = (shadow_cursor + 1) % span;
                for (n = 0; n < span && !found; n++) begin
                    if (!page_taken[probe]) begin
                        found             = 1'b1;
                        page_taken[probe] = 1'b1;
                        shadow_cursor     = probe[PG_W-1:0];
                        o.page            = probe[PG_W-1:0];
                    end else begin
                        probe = (probe + 1) % span;
                    end
                end
                if (!found)
                    o.status = pfa_pkg::ST_NO_FREE;
            end
            pfa_pkg::CMD_FREE: begin
                if (c.page >= span)
                    o.status = pfa_pkg::ST_RANGE;
                else if (!page_taken[c.page])
                    o.status = pfa_pkg::ST_NOT_USED;
                else
                    page_taken[c.page] = 1'b0;
            end
            pfa_pkg::CMD_RESERVE: begin
                // inclusive range, clipped to the count; empty when first > last
                for (i = c.page; i <= c.last && i < span; i++)
                    page_taken[i] = 1'b1;
            end
            default: begin
                shadow_cursor = c.page;
            end
        endcase
        return o;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        $display("[%0t] mismatch on result %0d: %s got %0d want %0d",
                 $realtime, results_seen, what, got, want);
    endtask

    task automatic queue_item(input pfa_pkg::t_cmd op, input int unsigned page,
                              input int unsigned last);
        t_command c;
        c.op   = op;
        c.page = PG_W'(page);
        c.last = PG_W'(last);
        queued_commands.push_back(c);
        queued_total++;
    endtask

    // register write then read back; only called while no command is queued or in flight
    task automatic reg_write(input logic [CNT_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PAGE_COUNT_ADDR;
        pwdata  <= PDATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready)
            @(posedge i_clk);
        shadow_count = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready)
            @(posedge i_clk);
        if (o_prdata !== PDATA_W'(value))
            report_mismatch("page count read back", int'(o_prdata), int'(value));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait until every command has been taken and every result has come back
    task automatic drain();
        while (accepted_total != queued_total || awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // free target: usually a recently allocated page just below the cursor
    function automatic logic [PG_W-1:0] pick_free_target(input int unsigned span);
        logic [PG_W-1:0] cand;
        int unsigned     r;
        int unsigned     k;
        r = $urandom_range(0, 99);
        if (r < 15)
            return PG_W'($urandom);
        if (r < 35)
            return PG_W'($urandom_range(0, span - 1));
        for (k = 0; k < 16; k++) begin
            cand = PG_W'((shadow_cursor + span - ($urandom_range(0, 40) % span)) % span);
            if (page_taken[cand])
                return cand;
        end
        return PG_W'($urandom_range(0, span - 1));
    endfunction

    // one phase of random commands, weighted towards sequences that do real work
    task automatic fill_random(input int unsigned count);
        int unsigned span;
        int unsigned r;
        int unsigned first;
        int unsigned k;
        span = live_span();
        for (k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                queue_item(pfa_pkg::CMD_ALLOC, $urandom, $urandom);
            end else if (r < 70) begin
                queue_item(pfa_pkg::CMD_FREE, pick_free_target(span), $urandom);
            end else if (r < 85) begin
                r     = $urandom_range(0, 99);
                first = $urandom_range(0, span - 1);
                if (r < 70)
                    queue_item(pfa_pkg::CMD_RESERVE, first,
                               (first + $urandom_range(0, 7) > PAGES_DEF - 1) ?
                               PAGES_DEF - 1 : first + $urandom_range(0, 7));
                else if (r < 85)
                    queue_item(pfa_pkg::CMD_RESERVE, $urandom, $urandom);
                else
                    queue_item(pfa_pkg::CMD_RESERVE, first, PAGES_DEF - 1);
            end else begin
                if ($urandom_range(0, 9) < 6)
                    queue_item(pfa_pkg::CMD_CURSOR, $urandom_range(0, span - 1), $urandom);
                else
                    queue_item(pfa_pkg::CMD_CURSOR, $urandom, $urandom);
            end
        end
    endtask

    // rising edge: take note of both transfers, predict and check
    always @(posedge i_clk) begin
        t_command c;
        t_outcome want;
        t_outcome got;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && s_valid && o_s_tready) begin
            c.op   = pfa_pkg::t_cmd'(s_user);
            c.page = s_data[PG_W-1:0];
            c.last = s_data[2*PG_W-1:PG_W];
            want   = allocator_step(c);
            if (c.op == pfa_pkg::CMD_ALLOC) begin
                if (want.status == pfa_pkg::ST_OK)
                    alloc_hits++;
                else
                    alloc_misses++;
            end
            awaited_results.push_back(want);
            accepted_total++;
            s_fire = 1'b1;
        end else begin
            s_fire = 1'b0;
        end
        if (i_rst_n && m_ready && o_m_tvalid) begin
            got.page   = o_m_tdata[PG_W-1:0];
            got.status = pfa_pkg::t_status'(o_m_tdata[PG_W+STAT_W-1:PG_W]);
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited, page", int'(got.page), 0);
            end else begin
                want = awaited_results.pop_front();
                if (got.page !== want.page)
                    report_mismatch("result_page", int'(got.page), int'(want.page));
                if (got.status !== want.status)
                    report_mismatch("status", int'(got.status), int'(want.status));
            end
            results_seen++;
        end
    end

    // watchdog on the whole run
    always @(posedge i_clk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // sender: offers the queued commands, with random gaps between transfers outside steady phases
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (gap_left > 0) begin
                s_valid  <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (queued_commands.size() != 0) begin
                outgoing = queued_commands.pop_front();
                s_valid  <= 1'b1;
                s_user   <= outgoing.op;
                s_data   <= {outgoing.last, outgoing.page};
                gap_left <= steady ? 0 : idle_len();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, once, while the sender still has plenty to offer
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_seen >= 120 && queued_commands.size() > 20) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
        end
    end

    // receiver: random stalls, none during steady phases
    always @(negedge i_clk) begin
        if (!i_rst_n || hold_left > 0) begin
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= idle_len();
        end
    end

    // phases: directed corners first, then random traffic over a range of page counts
    initial begin
        logic [CNT_W-1:0] phase_counts [12];
        int unsigned      p;
        phase_counts = '{13'd8191, 13'd1, 13'd2, 13'd5, 13'd64, 13'd65,
                         13'd127, 13'd4096, 13'd0, 13'd200, 13'd4095, 13'd3000};

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // full bitmap: wrap of the first probe, ranges at the top page, empty range
        reg_write(13'd4096);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);
        queue_item(pfa_pkg::CMD_ALLOC, PAGES_DEF - 1, PAGES_DEF - 1);
        queue_item(pfa_pkg::CMD_FREE, 1, 0);
        queue_item(pfa_pkg::CMD_FREE, 1, 0);              // second free of the same page
        queue_item(pfa_pkg::CMD_FREE, PAGES_DEF - 1, 0);  // in range but never used
        queue_item(pfa_pkg::CMD_CURSOR, PAGES_DEF - 1, 0);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);             // probe wraps to page zero
        queue_item(pfa_pkg::CMD_RESERVE, PAGES_DEF - 2, PAGES_DEF - 1);
        queue_item(pfa_pkg::CMD_CURSOR, PAGES_DEF - 3, 0);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);             // skips the reserved top pages
        queue_item(pfa_pkg::CMD_RESERVE, 10, 5);          // first page after last page
        queue_item(pfa_pkg::CMD_FREE, 10, 0);
        queue_item(pfa_pkg::CMD_RESERVE, 3, 3);
        queue_item(pfa_pkg::CMD_FREE, 3, 0);
        queue_item(pfa_pkg::CMD_CURSOR, 0, 0);
        phase_count++;
        drain();

        // zero count behaves as one page
        reg_write(13'd0);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);             // only page taken: no free page
        queue_item(pfa_pkg::CMD_FREE, 1, 0);              // beyond the count
        queue_item(pfa_pkg::CMD_FREE, 0, 0);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);
        phase_count++;
        drain();

        // reserve clipped to the count, cursor far beyond the count
        reg_write(13'd64);
        queue_item(pfa_pkg::CMD_RESERVE, 0, PAGES_DEF - 1);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);
        queue_item(pfa_pkg::CMD_FREE, PAGES_DEF - 1, 0);
        queue_item(pfa_pkg::CMD_CURSOR, 4000, 0);
        queue_item(pfa_pkg::CMD_FREE, 17, 0);
        queue_item(pfa_pkg::CMD_ALLOC, 0, 0);
        phase_count++;
        drain();

        for (p = 0; p < 12; p++) begin
            steady = (p % 3 == 1);
            reg_write(phase_counts[p]);
            fill_random(PHASE_ITEMS);
            phase_count++;
            drain();
        end
        steady = 1'b0;

        // let any stray result show up before closing
        repeat (120) @(posedge i_clk);
        if (awaited_results.size() != 0)
            report_mismatch("results never delivered", 0, awaited_results.size());

        $display("run covered %0d commands over %0d page count settings in %0d cycles",
                 accepted_total, phase_count, cycle_count);
        $display("allocations: %0d granted, %0d refused for lack of a free page",
                 alloc_hits, alloc_misses);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/pfa_pkg.sv
design/pfa_datapath.sv
design/pfa_ctrl.sv
design/page_frame_allocator_core.sv
test/tb_page_frame_allocator_core.sv
